[hdl/refcounted_tag_slot_allocator_assert.svh]
// ============================================================================
// Assertion macros for the tag slot allocator
// Immediate-implication and next-cycle-implication property wrappers.
// ============================================================================
`ifndef REFCOUNTED_TAG_SLOT_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_TAG_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle
`define RTSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtsa assertion failed");

// Antecedent implies consequent in the next cycle
`define RTSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtsa assertion failed");

`else

`define RTSA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RTSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/rtsa_pkg.sv]
// ============================================================================
// Tag slot allocator package
// Shared widths, operation codes, lookup flags and the saturating increment.
// ============================================================================
package rtsa_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int OP_W          = 2;
    localparam int TAG_W         = 16;
    localparam int CNT_W         = 8;
    localparam int SLOT_OUT_W    = 4;

    // Request operation codes; the fourth code is a no-op
    typedef enum logic [OP_W-1:0] {
        OP_ACQUIRE = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    // Lookup summary handed from the match logic to the update logic
    typedef struct packed {
        logic hit;
        logic free_found;
    } lkp_flags_t;

    // Count increment that sticks at the maximum
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

[hdl/rtsa_req_if.sv]
// ============================================================================
// Request channel
// Valid/ready channel carrying one allocator request per transfer.
// ============================================================================
interface rtsa_req_if;
    logic                         valid;
    logic                         ready;
    logic [rtsa_pkg::OP_W-1:0]    op;
    logic [rtsa_pkg::TAG_W-1:0]   tag;
    logic [3:0]                   release_slot;

    modport source (output valid, op, tag, release_slot, input ready);
    modport sink   (input valid, op, tag, release_slot, output ready);
endinterface

[hdl/rtsa_rsp_if.sv]
// ============================================================================
// Response channel
// Valid/ready channel carrying one allocator result per transfer.
// ============================================================================
interface rtsa_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [rtsa_pkg::SLOT_OUT_W-1:0]   granted_slot;
    logic                              newly_allocated;
    logic                              fallback_used;
    logic [rtsa_pkg::CNT_W-1:0]        count_after;

    modport source (output valid, granted_slot, newly_allocated, fallback_used,
                    count_after, input ready);
    modport sink   (input valid, granted_slot, newly_allocated, fallback_used,
                    count_after, output ready);
endinterface

[hdl/rtsa_lookup.sv]
// ============================================================================
// Tag slot lookup
// Parallel tag compare over live slots plus lowest-index priority encoders
// for the matching slot and the first free slot.
// ============================================================================
module rtsa_lookup #(
    parameter int SLOTS  = rtsa_pkg::SLOTS_DEFAULT,
    parameter int SLOT_W = 4
) (
    input  logic [rtsa_pkg::TAG_W-1:0] slot_tag [SLOTS],
    input  logic [rtsa_pkg::CNT_W-1:0] slot_refs [SLOTS],
    input  logic [rtsa_pkg::TAG_W-1:0] tag,
    output rtsa_pkg::lkp_flags_t       flags,
    output logic [SLOT_W-1:0]          hit_idx,
    output logic [SLOT_W-1:0]          free_idx,
    output logic [SLOTS-1:0]           live
);

    logic [SLOTS-1:0] match;

    // Per-slot live and match bits
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            live[i]  = (slot_refs[i] != '0);
            match[i] = live[i] && (slot_tag[i] == tag);
        end
    end

    // Lowest-index encoders: scan downward so the lowest hit wins
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = SLOT_W'(i);
            end
            if (!live[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
        flags.hit        = |match;
        flags.free_found = ~&live;
    end

endmodule

[hdl/refcounted_tag_slot_allocator.sv]
// ============================================================================
// Reference-counted tag slot allocator
// Path: input register, then table update and result register in one pass.
// Throughput: one request per cycle unless the response side stalls; the
// table is read and written in the same cycle, so back-to-back requests
// see each other's updates.
// Reset: asynchronous, clears both registers' valid bits and the whole table.
// ============================================================================
`include "refcounted_tag_slot_allocator_assert.svh"

module refcounted_tag_slot_allocator #(
    parameter int SLOTS = rtsa_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    rtsa_req_if.sink    req,
    rtsa_rsp_if.source  rsp
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Input register
    logic                          in_valid_reg;
    rtsa_pkg::op_t                 op_reg;
    logic [rtsa_pkg::TAG_W-1:0]    tag_reg;
    logic [3:0]                    rs_reg;

    // Slot table
    logic [rtsa_pkg::TAG_W-1:0]    slot_tag_reg  [SLOTS];
    logic [rtsa_pkg::CNT_W-1:0]    slot_refs_reg [SLOTS];
    logic [rtsa_pkg::TAG_W-1:0]    slot_tag_next [SLOTS];
    logic [rtsa_pkg::CNT_W-1:0]    slot_refs_next[SLOTS];

    // Result register
    logic                              out_valid_reg;
    logic [rtsa_pkg::SLOT_OUT_W-1:0]   slot_out_reg,  slot_out_next;
    logic                              fresh_reg,     fresh_next;
    logic                              fb_reg,        fb_next;
    logic [rtsa_pkg::CNT_W-1:0]        cnt_reg,       cnt_next;

    rtsa_pkg::lkp_flags_t  flags;
    logic [SLOT_W-1:0]     hit_idx;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOTS-1:0]      live;
    logic                  fire;
    logic [SLOT_W-1:0]     rs_idx;
    logic                  rs_in_range;
    logic [rtsa_pkg::CNT_W-1:0] rel_cnt;

    // Terms for the checks
    logic                  clear_fire;
    logic                  fresh_ok;

    // Handshake: stage advances when the result register is free or drains
    assign fire      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || fire;

    assign rsp.valid           = out_valid_reg;
    assign rsp.granted_slot    = slot_out_reg;
    assign rsp.newly_allocated = fresh_reg;
    assign rsp.fallback_used   = fb_reg;
    assign rsp.count_after     = cnt_reg;

    rtsa_lookup #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_lookup (
        .slot_tag  (slot_tag_reg),
        .slot_refs (slot_refs_reg),
        .tag       (tag_reg),
        .flags     (flags),
        .hit_idx   (hit_idx),
        .free_idx  (free_idx),
        .live      (live)
    );

    assign rs_idx      = SLOT_W'(rs_reg);
    assign rs_in_range = (32'(rs_reg) < 32'(SLOTS));
    assign rel_cnt     = slot_refs_reg[rs_idx];

    // Table update and result for the registered request
    always_comb
    begin
        slot_tag_next  = slot_tag_reg;
        slot_refs_next = slot_refs_reg;
        slot_out_next  = '0;
        fresh_next     = 1'b0;
        fb_next        = 1'b0;
        cnt_next       = '0;
        unique case (op_reg)
            rtsa_pkg::OP_ACQUIRE:
            begin
                if (flags.hit)
                begin
                    cnt_next                = rtsa_pkg::sat_inc(slot_refs_reg[hit_idx]);
                    slot_refs_next[hit_idx] = cnt_next;
                    slot_out_next           = rtsa_pkg::SLOT_OUT_W'(hit_idx);
                end
                else if (flags.free_found)
                begin
                    slot_tag_next[free_idx]  = tag_reg;
                    slot_refs_next[free_idx] = rtsa_pkg::CNT_W'(1);
                    cnt_next                 = rtsa_pkg::CNT_W'(1);
                    slot_out_next            = rtsa_pkg::SLOT_OUT_W'(free_idx);
                    fresh_next               = 1'b1;
                end
                else
                begin
                    // Table full: overcount slot 0
                    cnt_next          = rtsa_pkg::sat_inc(slot_refs_reg[0]);
                    slot_refs_next[0] = cnt_next;
                    fb_next           = 1'b1;
                end
            end
            rtsa_pkg::OP_RELEASE:
            begin
                slot_out_next = rs_reg;
                if (rs_in_range && (rel_cnt != '0))
                begin
                    cnt_next               = rel_cnt - rtsa_pkg::CNT_W'(1);
                    slot_refs_next[rs_idx] = cnt_next;
                    if (cnt_next == '0)
                    begin
                        slot_tag_next[rs_idx] = '0;
                    end
                end
            end
            rtsa_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    slot_tag_next[i]  = '0;
                    slot_refs_next[i] = '0;
                end
            end
            default:
            begin
                // Unused code: no state change, zero result
            end
        endcase
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg  <= rtsa_pkg::op_t'(req.op);
            tag_reg <= req.tag;
            rs_reg  <= req.release_slot;
        end
    end

    // Slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_tag_reg[i]  <= '0;
                slot_refs_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            slot_tag_reg  <= slot_tag_next;
            slot_refs_reg <= slot_refs_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            slot_out_reg <= slot_out_next;
            fresh_reg    <= fresh_next;
            fb_reg       <= fb_next;
            cnt_reg      <= cnt_next;
        end
    end

    // Checks
    assign clear_fire = fire && (op_reg == rtsa_pkg::OP_CLEAR);
    assign fresh_ok   = (cnt_reg == rtsa_pkg::CNT_W'(1)) && !fb_reg;

    `RTSA_ASSERT_NEXT(a_clear_empties, clk, rst_n, clear_fire, live == '0)
    `RTSA_ASSERT_NOW(a_fresh_count_one, clk, rst_n, out_valid_reg && fresh_reg, fresh_ok)
    `RTSA_ASSERT_NOW(a_fallback_slot0, clk, rst_n, out_valid_reg && fb_reg, slot_out_reg == '0)

endmodule

[tb/sv/tb_refcounted_tag_slot_allocator.sv]
// ============================================================================
// Testbench for the reference-counted tag slot allocator
// Drives acquire, release, clear and unused-op requests through the request
// channel and keeps a shadow copy of the tag table. Each response transfer is
// checked field by field against the oldest predicted grant. Idle bursts on
// either channel vary by phase; the final back-to-back phase has none.
// ============================================================================
module tb_refcounted_tag_slot_allocator;

    localparam int SLOTS      = rtsa_pkg::SLOTS_DEFAULT;
    localparam int OP_W       = rtsa_pkg::OP_W;
    localparam int TAG_W      = rtsa_pkg::TAG_W;
    localparam int CNT_W      = rtsa_pkg::CNT_W;
    localparam int SLOT_OUT_W = rtsa_pkg::SLOT_OUT_W;
    // The fourth op code has no enum member; the block treats it as a no-op
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // One predicted response
    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  fresh;
        logic                  fallback;
        logic [CNT_W-1:0]      count;
    } grant_t;

    logic clk;
    logic rst_n;

    rtsa_req_if req_if ();
    rtsa_rsp_if rsp_if ();

    refcounted_tag_slot_allocator #(
        .SLOTS (SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow table and pending grants
    logic [TAG_W-1:0] shadow_tag  [SLOTS];
    logic [CNT_W-1:0] shadow_refs [SLOTS];
    grant_t           pending_grants [$];
    int unsigned      fail_cnt;

    // Idle odds: 0 means no idling, N means a burst starts with chance 1/N
    int unsigned src_gap_odds;
    int unsigned snk_stall_odds;

    // Tags that recur, so lookups hit and the table fills up
    logic [TAG_W-1:0] tag_pool [20];

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    // Update the shadow table for one accepted request and return its grant
    function automatic grant_t predict_grant(input logic [OP_W-1:0] op,
                                             input logic [TAG_W-1:0] tag,
                                             input logic [3:0] rel_slot);
        grant_t g;
        int     hit;
        int     free;
        g    = '0;
        hit  = -1;
        free = -1;
        case (op)
            rtsa_pkg::OP_ACQUIRE:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (hit < 0 && shadow_refs[i] != '0 && shadow_tag[i] == tag)
                        hit = i;
                    if (free < 0 && shadow_refs[i] == '0)
                        free = i;
                end
                if (hit >= 0)
                begin
                    if (shadow_refs[hit] != CNT_MAX)
                        shadow_refs[hit] = shadow_refs[hit] + CNT_W'(1);
                    g.slot  = SLOT_OUT_W'(hit);
                    g.count = shadow_refs[hit];
                end
                else if (free >= 0)
                begin
                    shadow_tag[free]  = tag;
                    shadow_refs[free] = CNT_W'(1);
                    g.slot  = SLOT_OUT_W'(free);
                    g.fresh = 1'b1;
                    g.count = CNT_W'(1);
                end
                else
                begin
                    // Table full: slot 0 gets overcounted
                    if (shadow_refs[0] != CNT_MAX)
                        shadow_refs[0] = shadow_refs[0] + CNT_W'(1);
                    g.fallback = 1'b1;
                    g.count    = shadow_refs[0];
                end
            end
            rtsa_pkg::OP_RELEASE:
            begin
                g.slot = rel_slot;
                if (rel_slot < SLOTS)
                begin
                    if (shadow_refs[rel_slot] != '0)
                    begin
                        shadow_refs[rel_slot] = shadow_refs[rel_slot] - CNT_W'(1);
                        if (shadow_refs[rel_slot] == '0)
                            shadow_tag[rel_slot] = '0;
                    end
                    g.count = shadow_refs[rel_slot];
                end
            end
            rtsa_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    shadow_tag[i]  = '0;
                    shadow_refs[i] = '0;
                end
            end
            default:
            begin
            end
        endcase
        return g;
    endfunction

    // Send one request, with an optional idle burst ahead of it.
    // Entered and left at a falling edge.
    task automatic send_req(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                            input logic [3:0] rel_slot);
        int unsigned gap;
        gap = 0;
        if (src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1)
            gap = $urandom_range(1, 5);
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= op;
        req_if.tag          <= tag;
        req_if.release_slot <= rel_slot;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_grants.push_back(predict_grant(op, tag, rel_slot));
        @(negedge clk);
    endtask

    // Hold off the request side until every pending grant has come back
    task automatic drain_grants();
        req_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_grants.size() != 0);
    endtask

    // One random request, mostly over the recurring tags
    task automatic send_random_req();
        int unsigned      pick;
        logic [TAG_W-1:0] tag;
        logic [3:0]       rel_slot;
        pick     = $urandom_range(0, 99);
        rel_slot = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) < 7)
            tag = tag_pool[$urandom_range(0, 19)];
        else
            tag = TAG_W'($urandom);
        if (pick < 55)
            send_req(rtsa_pkg::OP_ACQUIRE, tag, rel_slot);
        else if (pick < 94)
            send_req(rtsa_pkg::OP_RELEASE, tag, rel_slot);
        else if (pick < 97)
            send_req(OP_NOP, tag, rel_slot);
        else
            send_req(rtsa_pkg::OP_CLEAR, tag, rel_slot);
    endtask

    // Fill every slot, hit an existing tag, then overflow into slot 0
    task automatic test_fill_and_fallback();
        send_req(rtsa_pkg::OP_ACQUIRE, 16'h0000, 4'h0);
        send_req(rtsa_pkg::OP_ACQUIRE, 16'hFFFF, 4'hF);
        send_req(rtsa_pkg::OP_ACQUIRE, 16'h0000, 4'h0);
        for (int i = 2; i < SLOTS; i++)
            send_req(rtsa_pkg::OP_ACQUIRE, 16'h0100 + TAG_W'(i), 4'h0);
        send_req(rtsa_pkg::OP_ACQUIRE, 16'hABCD, 4'h0);
    endtask

    // Release to zero, release of a free slot, reuse of the freed slot
    task automatic test_release_paths();
        send_req(rtsa_pkg::OP_RELEASE, 16'h0000, 4'd1);
        send_req(rtsa_pkg::OP_RELEASE, 16'h0000, 4'd1);
        send_req(rtsa_pkg::OP_ACQUIRE, 16'hFFFF, 4'h0);
        send_req(rtsa_pkg::OP_RELEASE, 16'hFFFF, 4'd15);
        send_req(rtsa_pkg::OP_RELEASE, 16'hFFFF, 4'd15);
        send_req(rtsa_pkg::OP_ACQUIRE, 16'h0000, 4'hF);
    endtask

    // Unused op code leaves the table alone and answers with zeros
    task automatic test_unused_op();
        send_req(OP_NOP, 16'hFFFF, 4'hF);
        send_req(rtsa_pkg::OP_ACQUIRE, 16'h0000, 4'h0);
    endtask

    // Clear empties the table; tag 0 is then a new allocation
    task automatic test_clear();
        send_req(rtsa_pkg::OP_CLEAR, 16'hFFFF, 4'hF);
        send_req(rtsa_pkg::OP_ACQUIRE, 16'h0000, 4'h0);
    endtask

    // Drive one count to the top, then overflow into the saturated slot 0
    task automatic test_count_saturation();
        send_req(rtsa_pkg::OP_CLEAR, 16'h0000, 4'h0);
        for (int i = 0; i < 258; i++)
            send_req(rtsa_pkg::OP_ACQUIRE, 16'h5A5A, 4'h0);
        send_req(rtsa_pkg::OP_RELEASE, 16'h0000, 4'd0);
        send_req(rtsa_pkg::OP_ACQUIRE, 16'h5A5A, 4'h0);
        for (int i = 1; i < SLOTS; i++)
            send_req(rtsa_pkg::OP_ACQUIRE, 16'h7000 + TAG_W'(i), 4'h0);
        send_req(rtsa_pkg::OP_ACQUIRE, 16'h1234, 4'h0);
        send_req(rtsa_pkg::OP_ACQUIRE, 16'h4321, 4'h0);
    endtask

    // Mixed traffic in segments with different idle patterns
    task automatic test_random_traffic();
        for (int seg = 0; seg < 10; seg++)
        begin
            case (seg % 4)
                0:       begin src_gap_odds = 3; snk_stall_odds = 3; end
                1:       begin src_gap_odds = 0; snk_stall_odds = 0; end
                2:       begin src_gap_odds = 2; snk_stall_odds = 0; end
                default: begin src_gap_odds = 0; snk_stall_odds = 2; end
            endcase
            for (int i = 0; i < 100; i++)
                send_random_req();
            if (seg == 4)
                drain_grants();
        end
    endtask

    // Final phase: both sides always ready
    task automatic test_back_to_back();
        src_gap_odds   = 0;
        snk_stall_odds = 0;
        for (int i = 0; i < 150; i++)
            send_random_req();
    endtask

    // Response side ready, with random stall bursts
    initial
    begin : sink_ready
        int unsigned stall_left;
        stall_left    = 0;
        rsp_if.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else if (snk_stall_odds != 0 && $urandom_range(1, snk_stall_odds) == 1)
            begin
                rsp_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // Check each response transfer against the oldest pending grant
    always @(posedge clk)
    begin : grant_check
        grant_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_grants.size() == 0)
            begin
                $error("unexpected response: granted_slot %0d count_after %0d",
                       rsp_if.granted_slot, rsp_if.count_after);
                fail_cnt++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (rsp_if.granted_slot !== want.slot)
                begin
                    $error("granted_slot: expected %0d, got %0d",
                           want.slot, rsp_if.granted_slot);
                    fail_cnt++;
                end
                if (rsp_if.newly_allocated !== want.fresh)
                begin
                    $error("newly_allocated: expected %0d, got %0d",
                           want.fresh, rsp_if.newly_allocated);
                    fail_cnt++;
                end
                if (rsp_if.fallback_used !== want.fallback)
                begin
                    $error("fallback_used: expected %0d, got %0d",
                           want.fallback, rsp_if.fallback_used);
                    fail_cnt++;
                end
                if (rsp_if.count_after !== want.count)
                begin
                    $error("count_after: expected %0d, got %0d",
                           want.count, rsp_if.count_after);
                    fail_cnt++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.op           = rtsa_pkg::OP_ACQUIRE;
        req_if.tag          = '0;
        req_if.release_slot = '0;
        fail_cnt            = 0;
        src_gap_odds        = 3;
        snk_stall_odds      = 3;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_tag[i]  = '0;
            shadow_refs[i] = '0;
        end
        tag_pool[0] = 16'h0000;
        tag_pool[1] = 16'hFFFF;
        for (int i = 2; i < 20; i++)
            tag_pool[i] = TAG_W'($urandom);

        // Reset held, then released at a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fill_and_fallback();
        test_release_paths();
        test_unused_op();
        test_clear();
        test_count_saturation();
        test_random_traffic();
        test_back_to_back();

        // Let the last responses come back
        drain_grants();
        repeat (4) @(posedge clk);

        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
